@@ hdl/msra_pkg.sv @@
`timescale 1ns / 1ps

package msra_pkg;

  localparam int unsigned OpW     = 3;
  localparam int unsigned StW     = 3;
  localparam int unsigned AddrW   = 16;
  localparam int unsigned ValW    = 24;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned InDataW = 56;
  localparam int unsigned OutDataW = 40;
  localparam int unsigned QDepth  = 4;
  localparam int unsigned QAw     = 2;

  localparam logic [OpW-1:0] OP_READ  = 3'd0;
  localparam logic [OpW-1:0] OP_WRITE = 3'd1;
  localparam logic [OpW-1:0] OP_RX    = 3'd2;
  localparam logic [OpW-1:0] OP_TICK  = 3'd3;
  localparam logic [OpW-1:0] OP_CLEAR = 3'd4;

  localparam logic [StW-1:0] ST_OK       = 3'd0;
  localparam logic [StW-1:0] ST_TIMEOUT  = 3'd1;
  localparam logic [StW-1:0] ST_BADCODE  = 3'd2;
  localparam logic [StW-1:0] ST_CHECKSUM = 3'd3;
  localparam logic [StW-1:0] ST_LOCKED   = 3'd4;
  localparam logic [StW-1:0] ST_BUSY     = 3'd5;

  localparam logic [0:0] CFG_TIMEOUT = 1'd0;
  localparam logic [0:0] CFG_LIMIT   = 1'd1;

  localparam logic [ByteW-1:0] HDR_BYTE    = 8'hAA;
  localparam logic [ByteW-1:0] SEL_ADDR    = 8'hA3;
  localparam logic [ByteW-1:0] OPC_READ    = 8'hE3;
  localparam logic [ByteW-1:0] OPC_WRITE   = 8'hD3;
  localparam logic [ByteW-1:0] ACK_NODATA  = 8'hAD;
  localparam logic [ByteW-1:0] LEN_READ    = 8'd7;
  localparam logic [ByteW-1:0] LEN_WRITE   = 8'd10;

  // one queued job: a request frame or a completion
  typedef struct packed {
    logic              is_frame;
    logic              is_write;
    logic [AddrW-1:0]  addr;
    logic [ValW-1:0]   data;
    logic [StW-1:0]    status;
  } job_t;

endpackage

@@ hdl/msra_queue.sv @@
`timescale 1ns / 1ps

module msra_queue
  import msra_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head
);

  job_t slots [QDepth];
  logic [QAw-1:0] wr_ptr;
  logic [QAw-1:0] rd_ptr;
  logic [QAw:0]   count;

  assign full       = (count == (QAw+1)'(QDepth));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ hdl/msra_front.sv @@
`timescale 1ns / 1ps

module msra_front
  import msra_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               accept,
  input  logic [OpW-1:0]     operation,
  input  logic [AddrW-1:0]   address,
  input  logic [ValW-1:0]    write_value,
  input  logic [ByteW-1:0]   rx_byte,
  input  logic               take_magnitude,
  output logic               push,
  output job_t               push_job
);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_READ  = 2'd1;
  localparam logic [1:0] PH_WRITE = 2'd2;

  logic [15:0]      timeout_ticks;
  logic [7:0]       error_limit;
  logic [1:0]       phase, phase_next;
  logic [2:0]       byte_count, byte_count_next;
  logic [7:0]       running_sum, running_sum_next;
  logic [15:0]      tick_count, tick_count_next;
  logic [7:0]       error_count, error_count_next;
  logic             magnitude_pending, magnitude_pending_next;
  logic [ByteW-1:0] code_byte;
  logic [ValW-1:0]  reply_value;
  logic             store_code, store_val;
  logic [1:0]       val_sel;
  logic [15:0]      tick_inc;
  logic [ValW-1:0]  mag_value;
  logic             cmd_start;

  always_comb begin
    tick_inc  = (tick_count != 16'hFFFF) ? tick_count + 16'd1 : tick_count;
    mag_value = (magnitude_pending && reply_value[ValW-1]) ? ValW'(0 - reply_value)
                                                           : reply_value;
  end

  always_comb begin
    phase_next             = phase;
    byte_count_next        = byte_count;
    running_sum_next       = running_sum;
    tick_count_next        = tick_count;
    error_count_next       = error_count;
    magnitude_pending_next = magnitude_pending;
    store_code             = 1'b0;
    store_val              = 1'b0;
    val_sel                = 2'(byte_count - 3'd2);
    cmd_start              = 1'b0;
    push                   = 1'b0;
    push_job               = '0;
    if (accept) begin
      case (operation)
        OP_READ, OP_WRITE: begin
          push = 1'b1;
          if (phase != PH_IDLE) begin
            push_job.status = ST_BUSY;
          end else if (error_count >= error_limit) begin
            push_job.status = ST_LOCKED;
          end else begin
            cmd_start              = 1'b1;
            phase_next             = (operation == OP_WRITE) ? PH_WRITE : PH_READ;
            magnitude_pending_next = (operation == OP_READ) && take_magnitude;
            push_job.is_frame      = 1'b1;
            push_job.is_write      = (operation == OP_WRITE);
            push_job.addr          = address;
            push_job.data          = write_value;
          end
        end
        OP_RX: begin
          if (phase == PH_WRITE) begin
            cmd_start       = 1'b1;
            phase_next      = PH_IDLE;
            push            = 1'b1;
            push_job.status = (rx_byte == ACK_NODATA) ? ST_OK : ST_BADCODE;
          end else if (phase == PH_READ) begin
            if (byte_count < 3'd5) begin
              store_code       = (byte_count == 3'd0);
              store_val        = (byte_count >= 3'd2);
              running_sum_next = running_sum + rx_byte;
              byte_count_next  = byte_count + 3'd1;
            end else begin
              cmd_start  = 1'b1;
              phase_next = PH_IDLE;
              push       = 1'b1;
              if (code_byte != HDR_BYTE) begin
                push_job.status = ST_BADCODE;
              end else begin
                error_count_next = '0;
                if (rx_byte != 8'(0 - running_sum)) begin
                  push_job.status = ST_CHECKSUM;
                end else begin
                  push_job.status = ST_OK;
                  push_job.data   = mag_value;
                end
              end
            end
          end
        end
        OP_TICK: begin
          if (phase != PH_IDLE) begin
            tick_count_next = tick_inc;
            if (tick_inc >= timeout_ticks) begin
              if (phase == PH_READ && error_count != 8'hFF) begin
                error_count_next = error_count + 8'd1;
              end
              cmd_start       = 1'b1;
              phase_next      = PH_IDLE;
              push            = 1'b1;
              push_job.status = ST_TIMEOUT;
            end
          end
        end
        OP_CLEAR: begin
          error_count_next = '0;
        end
        default: begin
        end
      endcase
      // command start or finish both clear the per-command state
      if (cmd_start) begin
        byte_count_next  = '0;
        running_sum_next = '0;
        tick_count_next  = '0;
        if (phase_next == PH_IDLE) begin
          magnitude_pending_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (store_code) begin
      code_byte <= rx_byte;
    end
    if (store_val) begin
      reply_value[8*val_sel +: 8] <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks     <= 16'd100;
      error_limit       <= 8'd80;
      phase             <= PH_IDLE;
      byte_count        <= '0;
      running_sum       <= '0;
      tick_count        <= '0;
      error_count       <= '0;
      magnitude_pending <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TIMEOUT: timeout_ticks <= cfg_data;
          CFG_LIMIT:   error_limit   <= cfg_data[7:0];
          default:     timeout_ticks <= timeout_ticks;
        endcase
      end
      phase             <= phase_next;
      byte_count        <= byte_count_next;
      running_sum       <= running_sum_next;
      tick_count        <= tick_count_next;
      error_count       <= error_count_next;
      magnitude_pending <= magnitude_pending_next;
    end
  end

endmodule

@@ hdl/msra_back.sv @@
`timescale 1ns / 1ps

module msra_back
  import msra_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  job_t                head,
  output logic                pop,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OutDataW-1:0] m_tdata,
  output logic                m_tuser,
  output logic                m_tlast
);

  logic [3:0]       idx;
  logic [ByteW-1:0] sum;
  logic [3:0]       last_idx;
  logic             frame_last;
  logic             word_last;
  logic [ByteW-1:0] tx;
  logic             load;

  always_comb begin
    last_idx   = head.is_write ? 4'd9 : 4'd6;
    frame_last = (idx == last_idx);
    word_last  = !head.is_frame || frame_last;
    case (idx)
      4'd0:    tx = HDR_BYTE;
      4'd1:    tx = head.is_write ? LEN_WRITE : LEN_READ;
      4'd2:    tx = SEL_ADDR;
      4'd3:    tx = head.addr[7:0];
      4'd4:    tx = head.addr[15:8];
      4'd5:    tx = head.is_write ? OPC_WRITE : OPC_READ;
      4'd6:    tx = head.data[7:0];
      4'd7:    tx = head.data[15:8];
      4'd8:    tx = head.data[23:16];
      default: tx = '0;
    endcase
    if (frame_last) begin
      tx = 8'(0 - sum);
    end
    load = head_valid && (!m_tvalid || m_tready);
    pop  = load && word_last;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tuser <= !head.is_frame;
      m_tlast <= word_last;
      if (head.is_frame) begin
        m_tdata <= {5'b0, {ValW{1'b0}}, ST_OK, tx};
      end else begin
        m_tdata <= {5'b0, head.data, head.status, {ByteW{1'b0}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      idx      <= '0;
      sum      <= '0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (load) begin
        if (word_last) begin
          idx <= '0;
          sum <= '0;
        end else begin
          idx <= idx + 4'd1;
          sum <= sum + tx;
        end
      end
    end
  end

endmodule

@@ hdl/meter_serial_register_access_unit.sv @@
`timescale 1ns / 1ps
// Each accepted command or completion is queued as a job, then its words are registered out.
// One input word per cycle unless full; one output word per cycle unless m_tready is low.
// A 4-deep job queue parts the input decoder from the frame serialiser; input stalls when full.
// Reset (rst, synchronous, active high): idle, counts cleared, timeout 100, error limit 80.

module meter_serial_register_access_unit
  import msra_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                s_tvalid,
  output logic                s_tready,
  // address[15:0], write_value[39:16], rx_byte[47:40], take_magnitude[48], zero pad
  input  logic [InDataW-1:0]  s_tdata,
  // operation
  input  logic [OpW-1:0]      s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  // tx_byte[7:0], status[10:8], read_value[34:11], zero pad
  output logic [OutDataW-1:0] m_tdata,
  // kind
  output logic                m_tuser,
  output logic                m_tlast
);

  logic accept;
  logic push, pop, full, head_valid;
  job_t push_job, head;

  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;

  msra_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .accept         (accept),
    .operation      (s_tuser),
    .address        (s_tdata[15:0]),
    .write_value    (s_tdata[39:16]),
    .rx_byte        (s_tdata[47:40]),
    .take_magnitude (s_tdata[48]),
    .push           (push),
    .push_job       (push_job)
  );

  msra_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  msra_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule

@@ bench/tb_meter_serial_register_access_unit.sv @@
`timescale 1ns / 1ps

module tb_meter_serial_register_access_unit;
  import msra_pkg::*;

  localparam logic KIND_TX   = 1'b0;
  localparam logic KIND_DONE = 1'b1;
  localparam logic [ByteW-1:0] ACK_DATA = HDR_BYTE;
  localparam logic [OpW-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OpW-1:0] OP_SPARE_HI = 3'd7;
  localparam int RAND_ITEMS = 312;
  localparam int NUM_SETTINGS = 6;
  localparam int SETTLE_CYCLES = 10;

  // reply shapes for a pending command
  localparam int RSP_GOOD    = 0;
  localparam int RSP_BADCODE = 1;
  localparam int RSP_BADSUM  = 2;
  localparam int RSP_PARTIAL = 3;
  localparam int RSP_SILENT  = 4;

  typedef enum logic [1:0] {PH_IDLE, PH_READ, PH_WRITE} phase_e;

  typedef struct packed {
    logic             kind;
    logic [ByteW-1:0] tx;
    logic             last;
    logic [StW-1:0]   status;
    logic [ValW-1:0]  value;
  } word_t;

  class register_access_predictor;
    logic [15:0]      timeout_ticks;
    logic [7:0]       error_limit;
    phase_e           phase;
    logic [2:0]       byte_count;
    logic [ByteW-1:0] reply_bytes [5];
    logic [7:0]       running_sum;
    logic [15:0]      tick_count;
    logic [7:0]       error_count;
    logic             magnitude_pending;
    word_t            pending_words [$];
    int               errors;
    int               frames;
    int               done_by_status [6];

    function new();
      timeout_ticks = 16'd100;
      error_limit   = 8'd80;
      error_count   = 8'd0;
      errors        = 0;
      frames        = 0;
      foreach (done_by_status[i]) done_by_status[i] = 0;
      foreach (reply_bytes[i]) reply_bytes[i] = 8'h00;
      end_wait();
    endfunction

    function void end_wait();
      phase             = PH_IDLE;
      byte_count        = 3'd0;
      running_sum       = 8'h00;
      tick_count        = 16'd0;
      magnitude_pending = 1'b0;
    endfunction

    function void configure(logic [0:0] idx, logic [15:0] data);
      if (idx == CFG_TIMEOUT) timeout_ticks = data;
      else error_limit = data[7:0];
    endfunction

    function void push_word(logic kind, logic [ByteW-1:0] tx, logic last,
                            logic [StW-1:0] status, logic [ValW-1:0] value);
      word_t w;
      w.kind   = kind;
      w.tx     = tx;
      w.last   = last;
      w.status = status;
      w.value  = value;
      pending_words.push_back(w);
    endfunction

    function void take_request(logic [OpW-1:0] op, logic [AddrW-1:0] addr,
                               logic [ValW-1:0] wval, logic [ByteW-1:0] rx, logic mag);
      logic [ByteW-1:0] frame [$];
      logic [7:0]       sum;
      logic [7:0]       want;
      logic [ValW-1:0]  v;
      logic             code_ok;
      logic             use_mag;
      if (op == OP_READ || op == OP_WRITE) begin
        if (phase != PH_IDLE) begin
          push_word(KIND_DONE, 8'h00, 1'b1, ST_BUSY, 24'd0);
        end else if (error_count >= error_limit) begin
          push_word(KIND_DONE, 8'h00, 1'b1, ST_LOCKED, 24'd0);
        end else begin
          end_wait();
          phase = (op == OP_WRITE) ? PH_WRITE : PH_READ;
          magnitude_pending = (op == OP_READ) ? mag : 1'b0;
          frame.push_back(HDR_BYTE);
          frame.push_back((op == OP_WRITE) ? LEN_WRITE : LEN_READ);
          frame.push_back(SEL_ADDR);
          frame.push_back(addr[7:0]);
          frame.push_back(addr[15:8]);
          frame.push_back((op == OP_WRITE) ? OPC_WRITE : OPC_READ);
          if (op == OP_WRITE) begin
            frame.push_back(wval[7:0]);
            frame.push_back(wval[15:8]);
            frame.push_back(wval[23:16]);
          end
          sum = 8'h00;
          foreach (frame[i]) sum = sum + frame[i];
          frame.push_back(8'h00 - sum);
          foreach (frame[i])
            push_word(KIND_TX, frame[i], i == frame.size() - 1, ST_OK, 24'd0);
        end
      end else if (op == OP_RX) begin
        if (phase == PH_WRITE) begin
          end_wait();
          push_word(KIND_DONE, 8'h00, 1'b1, (rx == ACK_NODATA) ? ST_OK : ST_BADCODE, 24'd0);
        end else if (phase == PH_READ) begin
          if (byte_count < 3'd5) begin
            reply_bytes[byte_count] = rx;
            running_sum = running_sum + rx;
            byte_count++;
          end else begin
            want    = 8'h00 - running_sum;
            v       = {reply_bytes[4], reply_bytes[3], reply_bytes[2]};
            code_ok = reply_bytes[0] == ACK_DATA;
            use_mag = magnitude_pending;
            end_wait();
            if (!code_ok) begin
              push_word(KIND_DONE, 8'h00, 1'b1, ST_BADCODE, 24'd0);
            end else begin
              error_count = 8'd0;
              if (rx != want) begin
                push_word(KIND_DONE, 8'h00, 1'b1, ST_CHECKSUM, 24'd0);
              end else begin
                if (use_mag && v[23]) v = -v;
                push_word(KIND_DONE, 8'h00, 1'b1, ST_OK, v);
              end
            end
          end
        end
      end else if (op == OP_TICK) begin
        if (phase != PH_IDLE) begin
          if (tick_count != 16'hFFFF) tick_count++;
          if (tick_count >= timeout_ticks) begin
            if (phase == PH_READ && error_count != 8'hFF) error_count++;
            end_wait();
            push_word(KIND_DONE, 8'h00, 1'b1, ST_TIMEOUT, 24'd0);
          end
        end
      end else if (op == OP_CLEAR) begin
        error_count = 8'd0;
      end
    endfunction

    task flag(input string msg);
      errors++;
      $display("ERROR @%0t: %s", $time, msg);
    endtask

    task check_word(input word_t got);
      word_t want;
      if (pending_words.size() == 0) begin
        flag($sformatf("unexpected word kind %0d tx %02h status %0d value %06h",
                       got.kind, got.tx, got.status, got.value));
        return;
      end
      want = pending_words.pop_front();
      if (got.kind !== want.kind)
        flag($sformatf("kind %0d, expected %0d", got.kind, want.kind));
      if (got.tx !== want.tx)
        flag($sformatf("tx byte %02h, expected %02h", got.tx, want.tx));
      if (got.last !== want.last)
        flag($sformatf("last %0d, expected %0d", got.last, want.last));
      if (got.status !== want.status)
        flag($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.value !== want.value)
        flag($sformatf("read value %06h, expected %06h", got.value, want.value));
      if (want.kind == KIND_TX) begin
        if (want.last) frames++;
      end else begin
        done_by_status[want.status]++;
      end
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [0:0]          cfg_index = 1'b0;
  logic [15:0]         cfg_data = 16'd0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata = '0;
  logic [OpW-1:0]      s_tuser = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic                m_tuser;
  logic                m_tlast;

  register_access_predictor sb;
  bit gaps_on = 1'b1;
  int items_sent = 0;

  meter_serial_register_access_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Watchdog expired with %0d words outstanding", sb.pending_words.size());
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_word(input logic [OpW-1:0] op, input logic [AddrW-1:0] addr,
                           input logic [ValW-1:0] wval, input logic [ByteW-1:0] rx,
                           input logic mag);
    int gap;
    gap = gaps_on ? $urandom_range(7, 0) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {{(InDataW - 49){1'b0}}, mag, rx, wval, addr};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.take_request(op, addr, wval, rx, mag);
    items_sent++;
  endtask

  task automatic send_op(input logic [OpW-1:0] op);
    send_word(op, 16'($urandom), 24'($urandom), 8'($urandom), 1'($urandom));
  endtask

  task automatic send_cmd(input logic [OpW-1:0] op, input logic mag);
    send_word(op, 16'($urandom), 24'($urandom), 8'($urandom), mag);
  endtask

  task automatic send_rx(input logic [ByteW-1:0] b);
    send_word(OP_RX, 16'($urandom), 24'($urandom), b, 1'($urandom));
  endtask

  // six-byte read reply, optionally cut short or with a corrupted checksum
  task automatic send_read_reply(input logic [ByteW-1:0] code, input logic [ValW-1:0] value,
                                 input logic corrupt, input int nbytes);
    logic [ByteW-1:0] b [6];
    logic [7:0]       s;
    b[0] = code;
    b[1] = 8'($urandom);
    b[2] = value[7:0];
    b[3] = value[15:8];
    b[4] = value[23:16];
    s = 8'h00;
    for (int k = 0; k < 5; k++) s = s + b[k];
    b[5] = 8'h00 - s;
    if (corrupt) b[5] = b[5] ^ 8'($urandom_range(255, 1));
    for (int k = 0; k < nbytes; k++) send_rx(b[k]);
  endtask

  task automatic wait_out();
    int n;
    n = (sb.timeout_ticks > 16'd24) ? 24 : int'(sb.timeout_ticks);
    if (n == 0) n = 1;
    repeat (n) send_op(OP_TICK);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] tmo, input logic [7:0] lim);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TIMEOUT;
    cfg_data  <= tmo;
    @(posedge clk);
    cfg_index <= CFG_LIMIT;
    cfg_data  <= {8'd0, lim};
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.configure(CFG_TIMEOUT, tmo);
    sb.configure(CFG_LIMIT, {8'd0, lim});
  endtask

  function automatic int pick_reply();
    int r;
    r = $urandom_range(99, 0);
    if (r < 55) return RSP_GOOD;
    if (r < 65) return RSP_BADCODE;
    if (r < 75) return RSP_BADSUM;
    if (r < 87) return RSP_PARTIAL;
    return RSP_SILENT;
  endfunction

  task automatic read_exchange(input int shape);
    logic [ByteW-1:0] code;
    logic [ValW-1:0]  value;
    send_cmd(OP_READ, 1'($urandom));
    if ($urandom_range(9, 0) == 0) send_cmd(1'($urandom) ? OP_WRITE : OP_READ, 1'($urandom));
    code = ACK_DATA;
    if (shape == RSP_BADCODE) begin
      do code = 8'($urandom); while (code == ACK_DATA);
    end
    value = 24'($urandom);
    if ($urandom_range(7, 0) == 0) value = 24'h800000;
    case (shape)
      RSP_PARTIAL: begin
        send_read_reply(code, value, 1'b0, $urandom_range(5, 0));
        wait_out();
      end
      RSP_SILENT: wait_out();
      default: send_read_reply(code, value, shape == RSP_BADSUM, 6);
    endcase
  endtask

  task automatic write_exchange(input int shape);
    logic [ByteW-1:0] code;
    send_cmd(OP_WRITE, 1'($urandom));
    case (shape)
      RSP_BADCODE, RSP_BADSUM: begin
        do code = 8'($urandom); while (code == ACK_NODATA);
        send_rx(code);
      end
      RSP_SILENT: wait_out();
      default: send_rx(ACK_NODATA);
    endcase
  endtask

  // result side: random back-pressure, every accepted word checked in order
  initial begin : result_sink
    int gap;
    word_t got;
    while (rst) @(posedge clk);
    forever begin
      gap = gaps_on ? $urandom_range(7, 0) : 0;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      got.kind   = m_tuser;
      got.tx     = m_tdata[7:0];
      got.last   = m_tlast;
      got.status = m_tdata[10:8];
      got.value  = m_tdata[34:11];
      sb.check_word(got);
    end
  end

  initial begin : stimulus
    int target;
    int r;
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: ignored items, write ok / busy / bad code, magnitude of 0x800000,
    // two read timeouts into lockout, refused command, clear
    set_config(16'd3, 8'd2);
    send_op(OP_TICK);
    send_rx(8'hFF);
    send_word(OP_SPARE_HI, 16'hFFFF, 24'hFFFFFF, 8'hFF, 1'b1);
    send_word(OP_WRITE, 16'hFFFF, 24'hFFFFFF, 8'h00, 1'b0);
    send_word(OP_READ, 16'h0000, 24'h000000, 8'h00, 1'b1);
    send_rx(ACK_NODATA);
    send_word(OP_WRITE, 16'h0000, 24'h000000, 8'hFF, 1'b1);
    send_rx(8'h00);
    send_word(OP_READ, 16'hFFFF, 24'h000000, 8'h00, 1'b1);
    send_read_reply(ACK_DATA, 24'h800000, 1'b0, 6);
    send_word(OP_READ, 16'h00FF, 24'hFFFFFF, 8'hFF, 1'b0);
    repeat (3) send_op(OP_TICK);
    send_word(OP_READ, 16'hFF00, 24'h000000, 8'h00, 1'b0);
    repeat (3) send_op(OP_TICK);
    send_word(OP_WRITE, 16'h5A5A, 24'hA5A5A5, 8'h00, 1'b0);
    send_op(OP_CLEAR);

    for (int p = 0; p < NUM_SETTINGS; p++) begin
      drain();
      case (p)
        0: set_config(16'd1, 8'd1);
        1: set_config(16'd4, 8'd3);
        2: set_config(16'd0, 8'd2);
        3: set_config(16'hFFFF, 8'hFF);
        4: set_config(16'd12, 8'd80);
        default: set_config(16'd100, 8'd80);
      endcase
      target = items_sent + RAND_ITEMS / NUM_SETTINGS;
      while (items_sent < target) begin
        if ($urandom_range(15, 0) == 0) gaps_on = ~gaps_on;
        r = $urandom_range(99, 0);
        if (r < 40) read_exchange(pick_reply());
        else if (r < 62) write_exchange(pick_reply());
        else if (r < 70) send_op(OP_CLEAR);
        else if (r < 78) send_op(OP_TICK);
        else if (r < 84) send_rx(8'($urandom));
        else if (r < 89) send_op(3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO)));
        else if (r < 93) drain();
        else send_cmd(1'($urandom) ? OP_WRITE : OP_READ, 1'($urandom));
      end
    end

    drain();
    $display("Sent %0d input words over %0d register settings; %0d request frames checked",
             items_sent, NUM_SETTINGS + 1, sb.frames);
    $display("Completions: ok %0d, timeout %0d, bad code %0d, checksum %0d, locked %0d, busy %0d",
             sb.done_by_status[ST_OK], sb.done_by_status[ST_TIMEOUT],
             sb.done_by_status[ST_BADCODE], sb.done_by_status[ST_CHECKSUM],
             sb.done_by_status[ST_LOCKED], sb.done_by_status[ST_BUSY]);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
